// ===== rtl/rds_pkg.sv =====
// Shared types, constants and helpers of the Rayleigh direction sampler.
`timescale 1ns / 1ps
package rds_pkg;

   localparam int SAMPLE_WIDTH_DEF = 16;
   localparam int CUBE_W = 50;
   localparam int ROOT_CELLS = 16;
   localparam int SQRT_CELLS = 16;
   localparam int TRIG_LAT = 22;
   localparam int PIPE_LAT = ROOT_CELLS + SQRT_CELLS + 2;

   localparam logic [30:0] Q30_ONE = 31'h4000_0000;
   localparam logic [32:0] PI_Q31 = 33'd6746518852;
   localparam logic [27:0] RAYLEIGH_Q32 = 28'd256336978;

   localparam int SIN_K [5] = '{110, 72, 42, 20, 6};
   localparam int COS_K [6] = '{132, 90, 56, 30, 12, 2};

   typedef enum logic [1:0] {QUAD_I, QUAD_II, QUAD_III, QUAD_IV} quad_type;

   typedef struct packed {
      logic signed [CUBE_W-1:0] target;
      logic signed [15:0] c;
      logic [30:0] c2;
      logic signed [46:0] c3;
   } root_type;

   typedef struct packed {
      logic [30:0] rem;
      logic [15:0] r;
      logic signed [15:0] c;
      logic [30:0] c2;
   } sqrt_type;

   typedef struct packed {
      logic [31:0] x2;
      logic [30:0] t;
   } horner_type;

   typedef struct packed {
      logic [16:0] sphi;
      logic [16:0] cphi;
      logic sneg;
      logic cneg;
   } trig_type;

   // round Q30 product to Q15, apply sign, saturate to Q1.15
   function automatic logic [15:0] sat_q15(logic [33:0] prod, logic neg);
      logic [18:0] m;
      logic [15:0] res;
      m = 19'((prod + 34'd16384) >> 15);
      if (neg) begin
         res = (m > 19'd32768) ? 16'h8000 : 16'(19'd0 - m);
      end else begin
         res = (m > 19'd32767) ? 16'h7FFF : 16'(m);
      end
      return res;
   endfunction

endpackage

// ===== rtl/rds_req_if.sv =====
// Request channel: a pair of uniform samples per word.
`timescale 1ns / 1ps
interface rds_req_if #(parameter int SAMPLE_WIDTH = rds_pkg::SAMPLE_WIDTH_DEF);
   logic valid;
   logic ready;
   logic [SAMPLE_WIDTH-1:0] sample_u;
   logic [SAMPLE_WIDTH-1:0] sample_v;
   modport source (output valid, output sample_u, output sample_v, input ready);
   modport sink (input valid, input sample_u, input sample_v, output ready);
endinterface

// ===== rtl/rds_rsp_if.sv =====
// Response channel: direction and density per word.
`timescale 1ns / 1ps
interface rds_rsp_if;
   logic valid;
   logic ready;
   logic signed [15:0] dir_x;
   logic signed [15:0] dir_y;
   logic signed [15:0] dir_z;
   logic [15:0] density;
   modport source (output valid, output dir_x, output dir_y, output dir_z, output density,
                   input ready);
   modport sink (input valid, input dir_x, input dir_y, input dir_z, input density,
                 output ready);
endinterface

// ===== rtl/rds_root_cell.sv =====
// One bit of the cubic root search, with running square and cube.
`timescale 1ns / 1ps
module rds_root_cell #(parameter int BIT = 15) (
   input  logic clock,
   input  logic adv,
   input  rds_pkg::root_type from_prev,
   output rds_pkg::root_type to_next
);
   localparam int W = rds_pkg::CUBE_W;

   rds_pkg::root_type stage_ff, stage_in;
   logic signed [W-1:0] c_w, c2_w, c3_w, sh1, sh2, cube_t, cn_w, lin, lhs, c2n;

   always_comb begin
      c_w = W'(from_prev.c);
      c2_w = W'(from_prev.c2);
      c3_w = W'(from_prev.c3);
      sh2 = c2_w <<< BIT;
      sh1 = c_w <<< (2 * BIT);
      cube_t = c3_w + sh2 + (sh2 <<< 1) + sh1 + (sh1 <<< 1) + (W'(1) <<< (3 * BIT));
      cn_w = c_w + (W'(1) <<< BIT);
      lin = cn_w <<< 30;
      lhs = cube_t + lin + (lin <<< 1);
      c2n = c2_w + (c_w <<< (BIT + 1)) + (W'(1) <<< (2 * BIT));
      stage_in = from_prev;
      // keep the trial bit when the cubic stays at or below the target
      if (lhs <= from_prev.target) begin
         stage_in.c = 16'(cn_w);
         stage_in.c2 = 31'(c2n);
         stage_in.c3 = 47'(cube_t);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         stage_ff <= stage_in;
      end
   end

   assign to_next = stage_ff;
endmodule

// ===== rtl/rds_sqrt_cell.sv =====
// One bit of the square root of 1 - cos^2, carrying cos along.
`timescale 1ns / 1ps
module rds_sqrt_cell #(parameter int BIT = 15) (
   input  logic clock,
   input  logic adv,
   input  rds_pkg::sqrt_type from_prev,
   output rds_pkg::sqrt_type to_next
);
   rds_pkg::sqrt_type stage_ff, stage_in;
   logic [31:0] trial;

   always_comb begin
      trial = (32'(from_prev.r) << (BIT + 1)) + (32'(1) << (2 * BIT));
      stage_in = from_prev;
      if (32'(from_prev.rem) >= trial) begin
         stage_in.rem = 31'(32'(from_prev.rem) - trial);
         stage_in.r = from_prev.r | 16'(32'(1) << BIT);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         stage_ff <= stage_in;
      end
   end

   assign to_next = stage_ff;
endmodule

// ===== rtl/rds_horner_cell.sv =====
// One Horner step of the sine/cosine series: 1 - x2*t/K, three stages.
`timescale 1ns / 1ps
module rds_horner_cell #(parameter int K = 6) (
   input  logic clock,
   input  logic adv,
   input  rds_pkg::horner_type from_prev,
   output rds_pkg::horner_type to_next
);
   localparam logic [33:0] RECIP = 34'((64'd1 << 34) / K);

   logic [31:0] n_ff, n_in, n2_ff, q_ff, q_in;
   logic [31:0] x2a_ff, x2b_ff;
   logic [33:0] rem;
   logic [31:0] sub;
   logic [30:0] t_ff, t_in;
   logic [31:0] x2c_ff;

   always_comb begin
      n_in = 32'((64'(from_prev.x2) * 64'(from_prev.t)) >> 30);
      // reciprocal estimate is low by at most one
      q_in = 32'((66'(n_ff) * 66'(RECIP)) >> 34);
      rem = 34'(n2_ff) - 34'(q_ff) * 34'(K);
      sub = (rem >= 34'(K)) ? q_ff + 32'd1 : q_ff;
      t_in = (sub >= 32'(rds_pkg::Q30_ONE)) ? 31'd0 : 31'(32'(rds_pkg::Q30_ONE) - sub);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         n_ff <= n_in;
         x2a_ff <= from_prev.x2;
         q_ff <= q_in;
         n2_ff <= n_ff;
         x2b_ff <= x2a_ff;
         t_ff <= t_in;
         x2c_ff <= x2b_ff;
      end
   end

   assign to_next.x2 = x2c_ff;
   assign to_next.t = t_ff;
endmodule

// ===== rtl/rds_trig.sv =====
// Azimuth: quarter-wave sine and cosine, quadrant folding, 22 stages.
`timescale 1ns / 1ps
module rds_trig (
   input  logic clock,
   input  logic adv,
   input  logic [15:0] phase,
   output rds_pkg::trig_type trig
);
   logic [30:0] x_in;
   logic [30:0] x_dly_ff [20];
   rds_pkg::quad_type quad_dly_ff [21];
   logic [31:0] x2_ff, x2_in;
   rds_pkg::horner_type sin_link [6];
   rds_pkg::horner_type cos_link [7];
   logic [30:0] st_dly_ff [3];
   logic [30:0] sinv_ff, sinv_in;
   logic [30:0] cost_ff;
   logic [16:0] sq, cq;
   rds_pkg::trig_type trig_ff, trig_in;

   always_comb begin
      x_in = 31'((47'(phase[13:0]) * 47'(rds_pkg::PI_Q31)) >> 16);
      x2_in = 32'((62'(x_dly_ff[0]) * 62'(x_dly_ff[0])) >> 30);
      sinv_in = 31'((62'(x_dly_ff[19]) * 62'(st_dly_ff[2])) >> 30);
   end

   assign sin_link[0] = '{x2: x2_ff, t: rds_pkg::Q30_ONE};
   assign cos_link[0] = '{x2: x2_ff, t: rds_pkg::Q30_ONE};

   for (genvar i = 0; i < 5; i++) begin : g_sin
      rds_horner_cell #(.K(rds_pkg::SIN_K[i])) u_cell (
         .clock(clock), .adv(adv), .from_prev(sin_link[i]), .to_next(sin_link[i+1]));
   end
   for (genvar i = 0; i < 6; i++) begin : g_cos
      rds_horner_cell #(.K(rds_pkg::COS_K[i])) u_cell (
         .clock(clock), .adv(adv), .from_prev(cos_link[i]), .to_next(cos_link[i+1]));
   end

   always_comb begin
      sq = 17'((32'(sinv_ff) + 32'd16384) >> 15);
      cq = 17'((32'(cost_ff) + 32'd16384) >> 15);
      case (quad_dly_ff[20])
         rds_pkg::QUAD_I:   trig_in = '{sphi: sq, cphi: cq, sneg: 1'b0, cneg: 1'b0};
         rds_pkg::QUAD_II:  trig_in = '{sphi: cq, cphi: sq, sneg: 1'b0, cneg: 1'b1};
         rds_pkg::QUAD_III: trig_in = '{sphi: sq, cphi: cq, sneg: 1'b1, cneg: 1'b1};
         default:           trig_in = '{sphi: cq, cphi: sq, sneg: 1'b1, cneg: 1'b0};
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         x_dly_ff[0] <= x_in;
         for (int i = 1; i < 20; i++) begin
            x_dly_ff[i] <= x_dly_ff[i-1];
         end
         quad_dly_ff[0] <= rds_pkg::quad_type'(phase[15:14]);
         for (int i = 1; i < 21; i++) begin
            quad_dly_ff[i] <= quad_dly_ff[i-1];
         end
         x2_ff <= x2_in;
         // hold the sine series until the longer cosine series catches up
         st_dly_ff[0] <= sin_link[5].t;
         st_dly_ff[1] <= st_dly_ff[0];
         st_dly_ff[2] <= st_dly_ff[1];
         sinv_ff <= sinv_in;
         cost_ff <= cos_link[6].t;
         trig_ff <= trig_in;
      end
   end

   assign trig = trig_ff;
endmodule

// ===== rtl/rayleigh_direction_sampler_core.sv =====
// Rayleigh direction sampler: root and sqrt cell chains, azimuth unit, output stages.
// Stages: 16 root cells, 16 square-root cells, then the product and output registers.
// Throughput: one word per cycle while the output word is taken.
// The whole pipeline advances together and holds while the output word is not taken.
// Reset clears only the stage valid flags; data registers are not reset.
`timescale 1ns / 1ps
module rayleigh_direction_sampler_core #(
   parameter int SAMPLE_WIDTH = rds_pkg::SAMPLE_WIDTH_DEF
) (
   input logic clock,
   input logic reset,
   rds_req_if.sink req_ch,
   rds_rsp_if.source rsp_ch
);
   localparam int LAT = rds_pkg::PIPE_LAT;
   localparam int TDLY = rds_pkg::ROOT_CELLS + rds_pkg::SQRT_CELLS - rds_pkg::TRIG_LAT;

   logic adv;
   logic vld_ff [LAT];
   logic [15:0] phase;
   logic signed [rds_pkg::CUBE_W-1:0] target;
   rds_pkg::root_type root_link [rds_pkg::ROOT_CELLS+1];
   rds_pkg::sqrt_type sqrt_link [rds_pkg::SQRT_CELLS+1];
   rds_pkg::trig_type trig_out;
   rds_pkg::trig_type trig_dly_ff [TDLY];
   logic [33:0] px_ff, px_in, py_ff, py_in;
   logic [59:0] pd_ff, pd_in;
   logic sneg_ff, cneg_ff;
   logic signed [15:0] c_ff;
   logic signed [15:0] dx_ff, dy_ff, dz_ff;
   logic [15:0] dens_ff;

   assign adv = !vld_ff[LAT-1] || rsp_ch.ready;
   assign req_ch.ready = adv;

   if (SAMPLE_WIDTH >= 16) begin : g_phase_wide
      assign phase = req_ch.sample_v[SAMPLE_WIDTH-1 -: 16];
   end else begin : g_phase_narrow
      assign phase = 16'(req_ch.sample_v) << (16 - SAMPLE_WIDTH);
   end

   // target 2z scaled to the cubic's Q45 frame
   assign target = (rds_pkg::CUBE_W'(req_ch.sample_u)
                    - (rds_pkg::CUBE_W'(1) << (SAMPLE_WIDTH - 1))) << (48 - SAMPLE_WIDTH);

   assign root_link[0] = '{target: target, c: 16'sh8000, c2: rds_pkg::Q30_ONE,
                           c3: 47'sh6000_0000_0000};

   for (genvar i = 0; i < rds_pkg::ROOT_CELLS; i++) begin : g_root
      rds_root_cell #(.BIT(rds_pkg::ROOT_CELLS - 1 - i)) u_cell (
         .clock(clock), .adv(adv), .from_prev(root_link[i]), .to_next(root_link[i+1]));
   end

   assign sqrt_link[0] = '{rem: rds_pkg::Q30_ONE - root_link[rds_pkg::ROOT_CELLS].c2,
                           r: 16'd0, c: root_link[rds_pkg::ROOT_CELLS].c,
                           c2: root_link[rds_pkg::ROOT_CELLS].c2};

   for (genvar i = 0; i < rds_pkg::SQRT_CELLS; i++) begin : g_sqrt
      rds_sqrt_cell #(.BIT(rds_pkg::SQRT_CELLS - 1 - i)) u_cell (
         .clock(clock), .adv(adv), .from_prev(sqrt_link[i]), .to_next(sqrt_link[i+1]));
   end

   rds_trig u_trig (.clock(clock), .adv(adv), .phase(phase), .trig(trig_out));

   always_comb begin
      px_in = 34'(sqrt_link[rds_pkg::SQRT_CELLS].r) * 34'(trig_dly_ff[TDLY-1].cphi);
      py_in = 34'(sqrt_link[rds_pkg::SQRT_CELLS].r) * 34'(trig_dly_ff[TDLY-1].sphi);
      pd_in = 60'(32'(rds_pkg::Q30_ONE) + 32'(sqrt_link[rds_pkg::SQRT_CELLS].c2))
              * 60'(rds_pkg::RAYLEIGH_Q32);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LAT; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else if (adv) begin
         vld_ff[0] <= req_ch.valid;
         for (int i = 1; i < LAT; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         trig_dly_ff[0] <= trig_out;
         for (int i = 1; i < TDLY; i++) begin
            trig_dly_ff[i] <= trig_dly_ff[i-1];
         end
         px_ff <= px_in;
         py_ff <= py_in;
         pd_ff <= pd_in;
         cneg_ff <= trig_dly_ff[TDLY-1].cneg;
         sneg_ff <= trig_dly_ff[TDLY-1].sneg;
         c_ff <= sqrt_link[rds_pkg::SQRT_CELLS].c;
         dx_ff <= rds_pkg::sat_q15(px_ff, cneg_ff);
         dy_ff <= rds_pkg::sat_q15(py_ff, sneg_ff);
         dz_ff <= c_ff;
         dens_ff <= 16'((pd_ff + (60'd1 << 45)) >> 46);
      end
   end

   assign rsp_ch.valid = vld_ff[LAT-1];
   assign rsp_ch.dir_x = dx_ff;
   assign rsp_ch.dir_y = dy_ff;
   assign rsp_ch.dir_z = dz_ff;
   assign rsp_ch.density = dens_ff;
endmodule

// ===== bench/tb_rayleigh_direction_sampler_core.sv =====
// Testbench for the Rayleigh direction sampler: directed table, then random words.
`timescale 1ns / 1ps
module tb_rayleigh_direction_sampler_core;

   localparam int SW = rds_pkg::SAMPLE_WIDTH_DEF;
   localparam int N_RANDOM = 600;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam longint unsigned ONE_Q30 = 64'd1 << 30;
   localparam longint unsigned PI_FIX = 64'd6746518852;
   localparam longint unsigned RAYL_FIX = 64'd256336978;

   typedef struct packed {
      logic [15:0] dir_x;
      logic [15:0] dir_y;
      logic [15:0] dir_z;
      logic [15:0] density;
   } direction_type;

   typedef struct {
      logic [15:0] u;
      logic [15:0] v;
      bit          known;
      direction_type want;
   } stim_row_type;

   logic clock;
   logic reset;

   rds_req_if #(.SAMPLE_WIDTH(SW)) req_ch ();
   rds_rsp_if rsp_ch ();

   rayleigh_direction_sampler_core #(.SAMPLE_WIDTH(SW)) dut (
      .clock(clock),
      .reset(reset),
      .req_ch(req_ch.sink),
      .rsp_ch(rsp_ch.source)
   );

   direction_type pending_dirs[$];
   int mismatches = 0;
   int idle_cycles = 0;
   bit calm = 0;

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   function automatic longint signed cubic_of(longint signed c);
      return c * c * c + 3 * c * longint'(ONE_Q30);
   endfunction

   function automatic longint signed polar_cos(longint unsigned u);
      longint signed goal, lo, hi, mid;
      goal = (longint'(8 * u) - 4 * (longint'(1) << SW)) * (longint'(1) << (45 - SW));
      lo = -32768;
      hi = 32767;
      while (lo < hi) begin
         mid = lo + (hi - lo + 1) / 2;
         if (cubic_of(mid) <= goal) lo = mid;
         else hi = mid - 1;
      end
      return lo;
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return res;
   endfunction

   function automatic longint unsigned horner(longint unsigned x2, longint unsigned t,
                                              longint unsigned k);
      longint unsigned sub;
      sub = ((x2 * t) >> 30) / k;
      return (sub >= ONE_Q30) ? 64'd0 : ONE_Q30 - sub;
   endfunction

   function automatic logic [15:0] signed_scale(longint unsigned a, longint unsigned b, bit neg);
      longint unsigned m;
      m = (a * b + (64'd1 << 14)) >> 15;
      if (neg) return (m > 32768) ? 16'h8000 : 16'(-longint'(m));
      return (m > 32767) ? 16'h7FFF : 16'(m);
   endfunction

   function automatic direction_type predict_direction(logic [15:0] su, logic [15:0] sv);
      direction_type d;
      longint signed c;
      longint unsigned c2, s, x, x2, t, sq, cq, sphi, cphi, phase;
      rds_pkg::quad_type quad;
      bit sneg, cneg;
      c = polar_cos(longint'(su));
      c2 = longint'(c * c);
      s = int_sqrt(ONE_Q30 - c2);
      phase = longint'(sv);
      quad = rds_pkg::quad_type'(phase[15:14]);
      x = ((phase & 64'h3FFF) * PI_FIX) >> 16;
      x2 = (x * x) >> 30;
      t = ONE_Q30;
      for (int i = 0; i < $size(rds_pkg::SIN_K); i++)
         t = horner(x2, t, longint'(rds_pkg::SIN_K[i]));
      sq = (((x * t) >> 30) + (64'd1 << 14)) >> 15;
      t = ONE_Q30;
      for (int i = 0; i < $size(rds_pkg::COS_K); i++)
         t = horner(x2, t, longint'(rds_pkg::COS_K[i]));
      cq = (t + (64'd1 << 14)) >> 15;
      case (quad)
         rds_pkg::QUAD_I: begin sphi = sq; cphi = cq; sneg = 0; cneg = 0; end
         rds_pkg::QUAD_II: begin sphi = cq; cphi = sq; sneg = 0; cneg = 1; end
         rds_pkg::QUAD_III: begin sphi = sq; cphi = cq; sneg = 1; cneg = 1; end
         default: begin sphi = cq; cphi = sq; sneg = 1; cneg = 0; end
      endcase
      d.dir_x = signed_scale(s, cphi, cneg);
      d.dir_y = signed_scale(s, sphi, sneg);
      d.dir_z = 16'(c);
      d.density = 16'((((ONE_Q30 + c2) * RAYL_FIX) + (64'd1 << 45)) >> 46);
      return d;
   endfunction

   task automatic send_word(logic [15:0] u, logic [15:0] v, bit known, direction_type want);
      direction_type d;
      while (!calm && $urandom_range(99) < 10) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      d = known ? want : predict_direction(u, v);
      req_ch.valid <= 1'b1;
      req_ch.sample_u <= u;
      req_ch.sample_v <= v;
      do @(posedge clock); while (!req_ch.ready);
      pending_dirs.push_back(d);
   endtask

   // drop valid and hold until every expected word has come back
   task automatic drain_all();
      req_ch.valid <= 1'b0;
      while (pending_dirs.size() != 0) @(posedge clock);
   endtask

   // receiver stall and checking
   always @(posedge clock) begin
      direction_type got, exp_d;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = {rsp_ch.dir_x, rsp_ch.dir_y, rsp_ch.dir_z, rsp_ch.density};
            if (pending_dirs.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected word %h", got);
            end else begin
               exp_d = pending_dirs.pop_front();
               if (got !== exp_d) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected x=%h y=%h z=%h d=%h got x=%h y=%h z=%h d=%h",
                        exp_d.dir_x, exp_d.dir_y, exp_d.dir_z, exp_d.density,
                        got.dir_x, got.dir_y, got.dir_z, got.density);
               end
            end
         end
         rsp_ch.ready <= calm || ($urandom_range(99) >= 10);
      end
   end

   // watchdog on cycles with no accepted word
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG_LIMIT) begin
         $display("watchdog expired");
         $display("FAILED: results differ");
         $finish;
      end
   end

   initial begin
      stim_row_type rows[$];
      logic [15:0] u, v;
      int mode;
      req_ch.valid = 0;
      req_ch.sample_u = 0;
      req_ch.sample_v = 0;
      reset = 1;
      repeat (7) @(posedge clock);
      reset <= 0;

      // u = 0: cos saturates at -1, sine zero, density at the top
      rows.push_back('{16'h0000, 16'h0000, 1, '{16'h0000, 16'h0000, 16'h8000, 16'h1E8F}});
      // u = 1/2: cos 0, sine 1, x saturates
      rows.push_back('{16'h8000, 16'h0000, 1, '{16'h7FFF, 16'h0000, 16'h0000, 16'h0F47}});
      rows.push_back('{16'hFFFF, 16'h0000, 0, '0});
      rows.push_back('{16'hFFFF, 16'hFFFF, 0, '0});
      rows.push_back('{16'h0000, 16'hFFFF, 0, '0});
      rows.push_back('{16'h8000, 16'h4000, 0, '0});
      rows.push_back('{16'h8000, 16'h8000, 0, '0});
      rows.push_back('{16'h8000, 16'hC000, 0, '0});
      rows.push_back('{16'h8000, 16'h3FFF, 0, '0});
      rows.push_back('{16'h7FFF, 16'h2000, 0, '0});
      rows.push_back('{16'h8001, 16'h6000, 0, '0});
      rows.push_back('{16'h4000, 16'hA000, 0, '0});
      rows.push_back('{16'hC000, 16'hE000, 0, '0});
      rows.push_back('{16'h0001, 16'h0001, 0, '0});
      rows.push_back('{16'hFFFE, 16'h7FFF, 0, '0});
      rows.push_back('{16'h5555, 16'hAAAA, 0, '0});
      rows.push_back('{16'hAAAA, 16'h5555, 0, '0});
      foreach (rows[i]) send_word(rows[i].u, rows[i].v, rows[i].known, rows[i].want);

      // hold until the pipeline has drained
      drain_all();

      for (int n = 0; n < N_RANDOM; n++) begin
         calm = (n >= 200 && n < 300);
         mode = $urandom_range(9);
         u = 16'($urandom);
         v = 16'($urandom);
         if (mode == 0) u = $urandom_range(1) ? 16'h0000 + 16'($urandom_range(3))
                                               : 16'hFFFF - 16'($urandom_range(3));
         if (mode == 1) v[13:0] = $urandom_range(1) ? 14'h0000 : 14'h3FFF;
         if (mode == 2) u = 16'h8000 + 16'($urandom_range(4)) - 16'd2;
         send_word(u, v, 0, '0);
         if (n == 400) drain_all();
      end
      calm = 0;
      drain_all();
      repeat (rds_pkg::PIPE_LAT + 10) @(posedge clock);
      if (mismatches == 0 && pending_dirs.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end
endmodule

// ===== files.f =====
rtl/rds_pkg.sv
rtl/rds_req_if.sv
rtl/rds_rsp_if.sv
rtl/rds_root_cell.sv
rtl/rds_sqrt_cell.sv
rtl/rds_horner_cell.sv
rtl/rds_trig.sv
rtl/rayleigh_direction_sampler_core.sv
bench/tb_rayleigh_direction_sampler_core.sv
